/* sv/wss_pkg.sv */
// wss_pkg: types, constants and widths shared by the window statistics unit
// depends on nothing; imported by the controller, the datapath and the top level
package wss_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int SAMPLE_W    = 32;
  localparam int FRAC_BITS   = 23;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int EDGE_W      = 12;
  localparam int SUM_W       = SAMPLE_W + $clog2(MAX_SAMPLES);
  localparam int SQ_W        = SAMPLE_W - 1;
  localparam int SQSUM_W     = SQ_W + $clog2(MAX_SAMPLES);
  localparam int RMS_W       = 31;
  localparam int ROOT_STEPS  = (SQ_W + FRAC_BITS + 1) / 2;
  localparam int RAD_W       = 2 * ROOT_STEPS;
  localparam int DIV_STEPS   = SUM_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  typedef enum logic [2:0] {
    ST_ACC,
    ST_LD_SUM,
    ST_DIV_SUM,
    ST_LD_SQ,
    ST_DIV_SQ,
    ST_LD_ROOT,
    ST_ROOT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic acc_en;
    logic ld_div_sum;
    logic ld_div_sq;
    logic save_mean;
    logic div_step;
    logic ld_root;
    logic root_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic root_last;
  } status_t;

endpackage

/* sv/wss_in_if.sv */
// wss_in_if: sample channel of the window statistics unit
// depends on wss_pkg for field widths
interface wss_in_if;
  import wss_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

/* sv/wss_out_if.sv */
// wss_out_if: result channel of the window statistics unit
// depends on wss_pkg for field widths
interface wss_out_if;
  import wss_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mean_value;
  logic        [RMS_W-1:0]    rms_value;
  logic signed [SAMPLE_W-1:0] peak_max;
  logic signed [SAMPLE_W-1:0] peak_min;
  logic                       edge_found;
  logic        [EDGE_W-1:0]   edge_index;

  modport source (output valid, mean_value, rms_value, peak_max, peak_min,
                  edge_found, edge_index, input ready);
  modport sink   (input valid, mean_value, rms_value, peak_max, peak_min,
                  edge_found, edge_index, output ready);
endinterface

/* sv/wss_ctrl.sv */
// wss_ctrl: sequencer for accumulate, divide, root and result hand-off
// depends on wss_pkg for state and command types
module wss_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  wss_pkg::status_t status,
  output wss_pkg::cmd_t   cmd
);
  import wss_pkg::*;

  state_t state_r, state_nxt;
  logic   s1_valid_r, s1_valid_nxt;
  logic   s1_last_r, s1_last_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      s1_valid_r  <= 1'b0;
      s1_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s1_last_r   <= s1_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    // the closing item of a window blocks intake until its result is loaded
    in_ready  = (state_r == ST_ACC) && !(s1_valid_r && s1_last_r);
    accept    = in_valid && in_ready;

    cmd.capture  = accept;
    cmd.acc_en   = s1_valid_r;
    s1_valid_nxt = accept;
    s1_last_nxt  = accept && in_last;

    unique case (state_r)
      ST_ACC: begin
        if (s1_valid_r && s1_last_r) state_nxt = ST_LD_SUM;
      end
      ST_LD_SUM: begin
        cmd.ld_div_sum = 1'b1;
        state_nxt      = ST_DIV_SUM;
      end
      ST_DIV_SUM: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_nxt = ST_LD_SQ;
      end
      ST_LD_SQ: begin
        cmd.save_mean = 1'b1;
        cmd.ld_div_sq = 1'b1;
        state_nxt     = ST_DIV_SQ;
      end
      ST_DIV_SQ: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_nxt = ST_LD_ROOT;
      end
      ST_LD_ROOT: begin
        cmd.ld_root = 1'b1;
        state_nxt   = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* sv/wss_datapath.sv */
// wss_datapath: window accumulators, shared restoring divider, bitwise root, result register
// depends on wss_pkg for widths and the command and status types
module wss_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wss_pkg::cmd_t              cmd,
  output wss_pkg::status_t           status,
  input  logic                       cfg_we,
  input  logic signed [31:0]         cfg_wdata,
  input  logic signed [31:0]         in_sample,
  output logic signed [31:0]         out_mean,
  output logic        [30:0]         out_rms,
  output logic signed [31:0]         out_max,
  output logic signed [31:0]         out_min,
  output logic                       out_edge_found,
  output logic        [11:0]         out_edge_index
);
  import wss_pkg::*;

  // threshold register
  logic signed [SAMPLE_W-1:0] thr_r;

  // capture stage: sample and its product
  logic signed [SAMPLE_W-1:0]   x_r;
  logic        [2*SAMPLE_W-1:0] prod_r;
  logic        [SAMPLE_W-1:0]   mag;

  // window state
  logic signed [SUM_W-1:0]    sum_r;
  logic        [SQSUM_W-1:0]  sqsum_r;
  logic signed [SAMPLE_W-1:0] max_r;
  logic signed [SAMPLE_W-1:0] min_r;
  logic        [CNT_W-1:0]    count_r;
  logic                       prev_below_r;
  logic                       edge_seen_r;
  logic        [EDGE_W-1:0]   edge_pos_r;

  // iterative units
  logic [SUM_W-1:0]  div_n_r;
  logic [CNT_W-1:0]  div_rem_r;
  logic              div_neg_r;
  logic [STEP_W-1:0] step_r;
  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_STEPS-1:0] root_r;
  logic [ROOT_STEPS+3:0] srem_r;
  logic signed [SAMPLE_W-1:0] mean_r;

  // result register
  logic signed [SAMPLE_W-1:0] res_mean_r;
  logic        [RMS_W-1:0]    res_rms_r;
  logic signed [SAMPLE_W-1:0] res_max_r;
  logic signed [SAMPLE_W-1:0] res_min_r;
  logic                       res_edge_r;
  logic        [EDGE_W-1:0]   res_idx_r;

  logic [2*SAMPLE_W-FRAC_BITS-SQ_W-1:0] sq_high;
  logic [SQ_W-1:0]       sq_sat;
  logic [SUM_W-1:0]      sum_mag;
  logic [CNT_W:0]        rem_sh;
  logic [CNT_W:0]        rem_diff;
  logic [SUM_W-1:0]      q_signed;
  logic [ROOT_STEPS+3:0] srem_sh;
  logic [ROOT_STEPS+3:0] trial;

  assign mag = in_sample[SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;

  // square is (x*x) >> 23, saturated to the largest positive sample
  assign sq_high = prod_r[2*SAMPLE_W-1:FRAC_BITS+SQ_W];
  assign sq_sat  = (|sq_high) ? SAMPLE_MAX[SQ_W-1:0] : prod_r[FRAC_BITS+SQ_W-1:FRAC_BITS];

  assign sum_mag  = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
  assign rem_sh   = {div_rem_r, div_n_r[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, count_r};
  assign q_signed = div_neg_r ? (~div_n_r + 1'b1) : div_n_r;

  assign srem_sh = {srem_r[ROOT_STEPS+1:0], rad_r[RAD_W-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};

  assign status.div_last  = (step_r == STEP_W'(DIV_STEPS - 1));
  assign status.root_last = (step_r == STEP_W'(ROOT_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r    <= in_sample;
      prod_r <= mag * mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_load) begin
      sum_r        <= '0;
      sqsum_r      <= '0;
      max_r        <= SAMPLE_MIN;
      min_r        <= SAMPLE_MAX;
      count_r      <= '0;
      prev_below_r <= 1'b0;
      edge_seen_r  <= 1'b0;
      edge_pos_r   <= '0;
    end else if (cmd.acc_en && (count_r < CNT_W'(MAX_SAMPLES))) begin
      sum_r   <= sum_r + SUM_W'(x_r);
      sqsum_r <= sqsum_r + SQSUM_W'(sq_sat);
      if (x_r > max_r) max_r <= x_r;
      if (x_r < min_r) min_r <= x_r;
      if (!edge_seen_r && prev_below_r && (x_r > thr_r)) begin
        edge_seen_r <= 1'b1;
        edge_pos_r  <= EDGE_W'(count_r);
      end
      prev_below_r <= (x_r < thr_r);
      count_r      <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_div_sum || cmd.ld_div_sq || cmd.ld_root) begin
      step_r <= '0;
    end else if (cmd.div_step || cmd.root_step) begin
      step_r <= step_r + 1'b1;
    end
  end

  // restoring divider by the sample count, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.ld_div_sum) begin
      div_n_r   <= sum_mag;
      div_rem_r <= '0;
      div_neg_r <= sum_r[SUM_W-1];
    end else if (cmd.ld_div_sq) begin
      div_n_r   <= SUM_W'(sqsum_r);
      div_rem_r <= '0;
      div_neg_r <= 1'b0;
    end else if (cmd.div_step) begin
      if (!rem_diff[CNT_W]) begin
        div_rem_r <= rem_diff[CNT_W-1:0];
        div_n_r   <= {div_n_r[SUM_W-2:0], 1'b1};
      end else begin
        div_rem_r <= rem_sh[CNT_W-1:0];
        div_n_r   <= {div_n_r[SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.save_mean) mean_r <= q_signed[SAMPLE_W-1:0];
  end

  // floor root of mean square scaled by 2^23, two radicand bits a cycle
  always_ff @(posedge clk) begin
    if (cmd.ld_root) begin
      rad_r  <= {div_n_r[SQ_W-1:0], {(RAD_W-SQ_W){1'b0}}};
      root_r <= '0;
      srem_r <= '0;
    end else if (cmd.root_step) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (srem_sh >= trial) begin
        srem_r <= srem_sh - trial;
        root_r <= {root_r[ROOT_STEPS-2:0], 1'b1};
      end else begin
        srem_r <= srem_sh;
        root_r <= {root_r[ROOT_STEPS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_mean_r <= mean_r;
      res_rms_r  <= RMS_W'(root_r);
      res_max_r  <= max_r;
      res_min_r  <= min_r;
      res_edge_r <= edge_seen_r;
      res_idx_r  <= edge_seen_r ? edge_pos_r : '0;
    end
  end

  assign out_mean       = res_mean_r;
  assign out_rms        = res_rms_r;
  assign out_max        = res_max_r;
  assign out_min        = res_min_r;
  assign out_edge_found = res_edge_r;
  assign out_edge_index = res_idx_r;

endmodule

/* sv/window_signal_statistics_unit.sv */
// window_signal_statistics_unit: windowed mean, rms, peaks and first rising edge
// one sample item per cycle is taken while a window accumulates; out valid rises after
// its last item is accumulated, then a divide per sum (sum, square sum), a root and a load
// intake pauses until the result is loaded, and the pause lasts
// longer while an earlier result still waits for out ready
// synchronous active-low reset clears the window, the threshold (to 0) and the result valid
module window_signal_statistics_unit (
  input  logic              clk,
  input  logic              rst_n,
  wss_in_if.sink            in_ch,
  wss_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic signed [31:0] cfg_wdata
);
  import wss_pkg::*;

  cmd_t    cmd;
  status_t status;

  wss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  wss_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_sample      (in_ch.sample),
    .out_mean       (out_ch.mean_value),
    .out_rms        (out_ch.rms_value),
    .out_max        (out_ch.peak_max),
    .out_min        (out_ch.peak_min),
    .out_edge_found (out_ch.edge_found),
    .out_edge_index (out_ch.edge_index)
  );

endmodule

/* tb/sv/testbench.sv */
// testbench: self-checking bench for window_signal_statistics_unit
// depends on wss_pkg, wss_in_if, wss_out_if and the unit itself
// a directed table, then random windows per threshold setting, checked by a local predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wss_pkg::*;

  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 140;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 120;
  // floor root of the saturated full-scale square
  localparam logic [RMS_W-1:0] FULL_SCALE_RMS = 31'd134217727;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean_value;
    logic        [RMS_W-1:0]    rms_value;
    logic signed [SAMPLE_W-1:0] peak_max;
    logic signed [SAMPLE_W-1:0] peak_min;
    logic                       edge_found;
    logic        [EDGE_W-1:0]   edge_index;
  } window_stats_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       typed;
    window_stats_t              want;
  } directed_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic signed [31:0]  cfg_wdata;

  wss_in_if  in_ch ();
  wss_out_if out_ch ();

  window_signal_statistics_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic signed [SAMPLE_W-1:0] edge_level;
  longint                     acc_sum;
  longint unsigned            acc_sq;
  logic signed [SAMPLE_W-1:0] acc_max;
  logic signed [SAMPLE_W-1:0] acc_min;
  longint                     acc_count;
  logic                       below_prev;
  logic                       edge_hit;
  longint                     edge_pos;

  window_stats_t pending_stats [$];
  int            mismatch_count = 0;
  int            quiet_cycles   = 0;
  bit            no_gaps        = 1'b0;
  bit            hold_req       = 1'b0;
  int            hold_left      = 0;

  directed_row_t directed_tbl [20] = '{
    '{SAMPLE_MAX, 1'b1, 1'b1,
      '{SAMPLE_MAX, FULL_SCALE_RMS, SAMPLE_MAX, SAMPLE_MAX, 1'b0, 12'd0}},
    '{SAMPLE_MIN, 1'b1, 1'b1,
      '{SAMPLE_MIN, FULL_SCALE_RMS, SAMPLE_MIN, SAMPLE_MIN, 1'b0, 12'd0}},
    '{32'sd0,    1'b1, 1'b1, '{32'sd0, 31'd0, 32'sd0, 32'sd0, 1'b0, 12'd0}},
    // simple crossing of zero
    '{-32'sd1,   1'b0, 1'b0, '0},
    '{32'sd1,    1'b1, 1'b1, '{32'sd0, 31'd0, 32'sd1, -32'sd1, 1'b1, 12'd1}},
    // a sample on the threshold breaks the crossing
    '{-32'sd5,   1'b0, 1'b0, '0},
    '{32'sd0,    1'b0, 1'b0, '0},
    '{32'sd5,    1'b1, 1'b1, '{32'sd0, 31'd0, 32'sd5, -32'sd5, 1'b0, 12'd0}},
    '{32'sd8388608,  1'b0, 1'b0, '0},
    '{-32'sd8388608, 1'b0, 1'b0, '0},
    '{32'sd16777216, 1'b1, 1'b0, '0},
    // negative mean truncates toward zero
    '{-32'sd7,   1'b0, 1'b0, '0},
    '{32'sd0,    1'b0, 1'b0, '0},
    '{32'sd0,    1'b1, 1'b0, '0},
    // only the first crossing counts
    '{-32'sd1,   1'b0, 1'b0, '0},
    '{32'sd1,    1'b0, 1'b0, '0},
    '{-32'sd1,   1'b0, 1'b0, '0},
    '{32'sd1,    1'b1, 1'b1, '{32'sd0, 31'd0, 32'sd1, -32'sd1, 1'b1, 12'd1}},
    '{SAMPLE_MIN, 1'b0, 1'b0, '0},
    '{SAMPLE_MAX, 1'b1, 1'b1,
      '{32'sd0, FULL_SCALE_RMS, SAMPLE_MAX, SAMPLE_MIN, 1'b1, 12'd1}}
  };

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic clear_window();
    acc_sum    = 0;
    acc_sq     = 0;
    acc_max    = SAMPLE_MIN;
    acc_min    = SAMPLE_MAX;
    acc_count  = 0;
    below_prev = 1'b0;
    edge_hit   = 1'b0;
    edge_pos   = 0;
  endtask

  function automatic longint unsigned sat_square(input logic signed [SAMPLE_W-1:0] s);
    longint          wide;
    longint unsigned mag;
    longint unsigned sq;
    wide = s;
    mag  = (wide < 0) ? -wide : wide;
    sq   = (mag * mag) >> FRAC_BITS;
    return (sq > longint'(SAMPLE_MAX)) ? longint'(SAMPLE_MAX) : sq;
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  task automatic accumulate_sample(input logic signed [SAMPLE_W-1:0] s, input logic is_last,
                                   output logic produced, output window_stats_t stats);
    longint unsigned mean_sq;
    longint unsigned root;
    stats    = '0;
    produced = is_last;
    // samples past the window limit touch no statistic
    if (acc_count < MAX_SAMPLES) begin
      acc_sum += s;
      acc_sq  += sat_square(s);
      if (s > acc_max) acc_max = s;
      if (s < acc_min) acc_min = s;
      if (!edge_hit && below_prev && s > edge_level) begin
        edge_hit = 1'b1;
        edge_pos = acc_count;
      end
      below_prev = s < edge_level;
      acc_count++;
    end
    if (is_last) begin
      mean_sq           = acc_sq / acc_count;
      root              = floor_root(mean_sq << FRAC_BITS);
      stats.mean_value  = SAMPLE_W'(acc_sum / acc_count);
      stats.rms_value   = root[RMS_W-1:0];
      stats.peak_max    = acc_max;
      stats.peak_min    = acc_min;
      stats.edge_found  = edge_hit;
      stats.edge_index  = edge_hit ? edge_pos[EDGE_W-1:0] : '0;
      clear_window();
    end
  endtask

  // called right after a rising edge; returns right after the edge that takes the item
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic is_last,
                             input logic typed, input window_stats_t want);
    window_stats_t predicted;
    logic          produced;
    while (!no_gaps && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    in_ch.last   <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    accumulate_sample(s, is_last, produced, predicted);
    if (produced) pending_stats.push_back(typed ? want : predicted);
  endtask

  task automatic load_threshold(input logic signed [SAMPLE_W-1:0] level);
    in_ch.valid <= 1'b0;
    wait (pending_stats.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= level;
    @(posedge clk);
    cfg_we     <= 1'b0;
    edge_level  = level;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    longint      v;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) begin
      // hover around the threshold so crossings happen often
      v = longint'(edge_level) + longint'($urandom_range(16)) - 8;
    end else if (roll < 70) begin
      return $urandom;
    end else if (roll < 85) begin
      v = longint'($urandom_range(32'h0400_0000)) - 64'sh0200_0000;
    end else if (roll < 95) begin
      case ($urandom_range(4))
        0:       return SAMPLE_MIN;
        1:       return SAMPLE_MAX;
        2:       return -32'sd1;
        3:       return 32'sd1;
        default: return 32'sd0;
      endcase
    end else begin
      return edge_level;
    end
    if (v > longint'(SAMPLE_MAX)) v = longint'(SAMPLE_MAX);
    if (v < longint'(SAMPLE_MIN)) v = longint'(SAMPLE_MIN);
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic run_phase(input logic signed [SAMPLE_W-1:0] level, input bit hold);
    int sent;
    int len;
    sent = 0;
    load_threshold(level);
    if (hold) hold_req = 1'b1;
    while (sent < PHASE_ITEMS) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
      for (int i = 0; i < len; i++) push_sample(pick_sample(), i == len - 1, 1'b0, '0);
      sent += len;
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req      = 1'b0;
        hold_left     = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_gaps || ($urandom_range(99) >= 13);
      end
    end
  end

  always @(posedge clk) begin : result_check
    window_stats_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_stats.size() == 0) begin
          report_mismatch("result item with nothing pending");
        end else begin
          want = pending_stats.pop_front();
          if (out_ch.mean_value !== want.mean_value)
            report_mismatch($sformatf("mean_value got %0d want %0d",
                                      out_ch.mean_value, want.mean_value));
          if (out_ch.rms_value !== want.rms_value)
            report_mismatch($sformatf("rms_value got %0d want %0d",
                                      out_ch.rms_value, want.rms_value));
          if (out_ch.peak_max !== want.peak_max)
            report_mismatch($sformatf("peak_max got %0d want %0d",
                                      out_ch.peak_max, want.peak_max));
          if (out_ch.peak_min !== want.peak_min)
            report_mismatch($sformatf("peak_min got %0d want %0d",
                                      out_ch.peak_min, want.peak_min));
          if (out_ch.edge_found !== want.edge_found)
            report_mismatch($sformatf("edge_found got %0b want %0b",
                                      out_ch.edge_found, want.edge_found));
          if (out_ch.edge_index !== want.edge_index)
            report_mismatch($sformatf("edge_index got %0d want %0d",
                                      out_ch.edge_index, want.edge_index));
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no item moved for %0d cycles", QUIET_LIMIT);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    logic signed [SAMPLE_W-1:0] level;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    in_ch.last   <= 1'b0;
    edge_level    = '0;
    clear_window();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // threshold still at its reset value of zero
    foreach (directed_tbl[r])
      push_sample(directed_tbl[r].sample, directed_tbl[r].last,
                  directed_tbl[r].typed, directed_tbl[r].want);

    // nothing can be below the lowest level or above the highest
    run_phase(SAMPLE_MIN, 1'b0);
    run_phase(SAMPLE_MAX, 1'b0);

    for (int p = 0; p < 7; p++) begin
      if (p % 2) level = $urandom;
      else       level = $signed($urandom_range(32'h0200_0000) - 32'h0100_0000);
      no_gaps = (p == 3);
      run_phase(level, p == 1);
    end
    no_gaps = 1'b0;

    in_ch.valid <= 1'b0;
    wait (pending_stats.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

/* files.f */
sv/wss_pkg.sv
sv/wss_in_if.sv
sv/wss_out_if.sv
sv/wss_ctrl.sv
sv/wss_datapath.sv
sv/window_signal_statistics_unit.sv
tb/sv/testbench.sv
